// File: design/tllm_pkg.sv
// shared types, constants and register codes for the text line layout measurer
package tllm_pkg;

  localparam int SCREEN_W_DEF     = 240;
  localparam int SCREEN_H_DEF     = 320;
  localparam int NARROW_WIDTH_DEF = 8;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  localparam int ADV_W   = 5;
  localparam int COORD_W = 16;
  localparam int EXT_W   = 18;
  localparam int SUM_W   = 20;
  localparam int LINE_W  = 12;
  localparam int FLAG_W  = 3;
  localparam int CFG_W   = 20;
  localparam int IDX_W   = 3;

  localparam logic [15:0] NEWLINE_CODE = 16'h0A00;
  localparam int          WIDE_W       = 16;
  localparam int          HALF_W       = 8;
  localparam int          LINE_STEP    = 18;
  localparam int          FONT_H       = 16;
  localparam int          RESET_CLIP_W = 240;
  localparam int          RESET_CLIP_H = 320;

  localparam int WRAP_NEWLINE = 0;
  localparam int WRAP_AUTO    = 1;
  localparam int WRAP_HALF    = 2;

  typedef enum logic [IDX_W-1:0] {
    CFG_START_X,
    CFG_START_Y,
    CFG_CLIP_LEFT,
    CFG_CLIP_TOP,
    CFG_CLIP_WIDTH,
    CFG_CLIP_HEIGHT,
    CFG_WRAP_FLAGS,
    CFG_START_OFFSET
  } cfg_idx_t;

  typedef struct packed {
    logic [ADV_W-1:0] adv;
    logic             newline;
    logic             first;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [COORD_W-1:0]     start_x;
    logic [COORD_W-1:0]     start_y;
    logic [COORD_W-1:0]     clip_left;
    logic [FLAG_W-1:0]      wrap_flags;
    logic [SUM_W-1:0]       start_offset;
    logic signed [EXT_W-1:0] max_x;
    logic signed [EXT_W-1:0] max_y;
  } lay_cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] pen_x;
    logic [COORD_W-1:0] pen_y;
    logic [SUM_W-1:0]   total_width;
    logic [SUM_W-1:0]   total_height;
    logic [LINE_W-1:0]  line_count;
    logic [SUM_W-1:0]   visible_index;
    logic               wrapped;
    logic               string_done;
  } res_t;

endpackage

// File: design/text_line_layout_measure.sv
// top level of the text line layout measurer: config registers, stages and queues
//
// usage:
//   input channel: drive in_code_unit, in_first_of_string, in_last_of_string
//   with in_push; a beat is taken at an edge where in_push is high and
//   in_full is low. in_first_of_string reloads pen and visible index from
//   config and resets totals and line count before laying out that character.
//   result channel: one result beat per input beat, in order. the oldest
//   result sits on the out_ ports while out_empty is low and leaves at an
//   edge where out_pop is high.
//   config port: cfg_we writes cfg_data into register cfg_index at the edge;
//   write only while no character is in flight.
// timing:
//   one character per cycle sustained while out_pop is high; the pen update is a
//   combinational add and compare loop in the layout stage. a result goes from
//   the input register through the middle queue and the layout stage into the
//   result queue.
// reset: rst_n low empties all queues and returns pen, totals and config
//   registers to their reset values.
// stall: with out_pop low the 2-entry result queue fills, then the 4-entry
//   middle queue, then the input register; in_full rises only then.
module text_line_layout_measure import tllm_pkg::*; #(
  parameter int SCREEN_W     = SCREEN_W_DEF,
  parameter int SCREEN_H     = SCREEN_H_DEF,
  parameter int NARROW_WIDTH = NARROW_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [15:0]           in_code_unit,
  input  logic                  in_first_of_string,
  input  logic                  in_last_of_string,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic signed [15:0]    out_pen_x,
  output logic signed [15:0]    out_pen_y,
  output logic [SUM_W-1:0]      out_total_width,
  output logic [SUM_W-1:0]      out_total_height,
  output logic [LINE_W-1:0]     out_line_count,
  output logic [SUM_W-1:0]      out_visible_index,
  output logic                  out_wrapped,
  output logic                  out_string_done,
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam logic signed [EXT_W-1:0] SCR_W = EXT_W'(SCREEN_W);
  localparam logic signed [EXT_W-1:0] SCR_H = EXT_W'(SCREEN_H);
  localparam int ITEM_BITS = $bits(item_t);
  localparam int RES_BITS  = $bits(res_t);

  logic [COORD_W-1:0] start_x_r, start_y_r, clip_left_r, clip_top_r;
  logic [COORD_W-1:0] clip_width_r, clip_height_r;
  logic [FLAG_W-1:0]  wrap_flags_r;
  logic [SUM_W-1:0]   start_offset_r;

  logic signed [EXT_W-1:0] max_x_r, max_x_nxt, max_y_r, max_y_nxt;
  logic signed [EXT_W-1:0] sum_x, sum_y;

  lay_cfg_t cfg;

  logic  mid_push, mid_full, mid_pop, mid_empty;
  item_t mid_wr, mid_rd;
  logic  [ITEM_BITS-1:0] mid_rd_bits;

  logic  res_push, res_full;
  res_t  res_wr, res_rd;
  logic  [RES_BITS-1:0] res_rd_bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r      <= '0;
      start_y_r      <= '0;
      clip_left_r    <= '0;
      clip_top_r     <= '0;
      clip_width_r   <= COORD_W'(RESET_CLIP_W);
      clip_height_r  <= COORD_W'(RESET_CLIP_H);
      wrap_flags_r   <= '0;
      start_offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START_X:      start_x_r      <= cfg_data[COORD_W-1:0];
        CFG_START_Y:      start_y_r      <= cfg_data[COORD_W-1:0];
        CFG_CLIP_LEFT:    clip_left_r    <= cfg_data[COORD_W-1:0];
        CFG_CLIP_TOP:     clip_top_r     <= cfg_data[COORD_W-1:0];
        CFG_CLIP_WIDTH:   clip_width_r   <= cfg_data[COORD_W-1:0];
        CFG_CLIP_HEIGHT:  clip_height_r  <= cfg_data[COORD_W-1:0];
        CFG_WRAP_FLAGS:   wrap_flags_r   <= cfg_data[FLAG_W-1:0];
        CFG_START_OFFSET: start_offset_r <= cfg_data[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  // rectangle edges clamped to the screen
  always_comb begin
    sum_x     = EXT_W'($signed(clip_left_r)) + EXT_W'($signed(clip_width_r));
    sum_y     = EXT_W'($signed(clip_top_r)) + EXT_W'($signed(clip_height_r));
    max_x_nxt = (sum_x > SCR_W) ? SCR_W : sum_x;
    max_y_nxt = (sum_y > SCR_H) ? SCR_H : sum_y;
  end

  always_ff @(posedge clk) begin
    max_x_r <= max_x_nxt;
    max_y_r <= max_y_nxt;
  end

  always_comb begin
    cfg.start_x      = start_x_r;
    cfg.start_y      = start_y_r;
    cfg.clip_left    = clip_left_r;
    cfg.wrap_flags   = wrap_flags_r;
    cfg.start_offset = start_offset_r;
    cfg.max_x        = max_x_r;
    cfg.max_y        = max_y_r;
  end

  tllm_front #(
    .NARROW_WIDTH(NARROW_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .code_unit       (in_code_unit),
    .first_of_string (in_first_of_string),
    .last_of_string  (in_last_of_string),
    .q_full          (mid_full),
    .q_push          (mid_push),
    .q_item          (mid_wr)
  );

  tllm_fifo #(
    .WIDTH(ITEM_BITS),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (mid_push),
    .wr_data (mid_wr),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_rd_bits),
    .empty   (mid_empty)
  );

  assign mid_rd = item_t'(mid_rd_bits);

  tllm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_empty  (mid_empty),
    .q_item   (mid_rd),
    .q_pop    (mid_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_wr)
  );

  tllm_fifo #(
    .WIDTH(RES_BITS),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_rd_bits),
    .empty   (out_empty)
  );

  assign res_rd            = res_t'(res_rd_bits);
  assign out_pen_x         = $signed(res_rd.pen_x);
  assign out_pen_y         = $signed(res_rd.pen_y);
  assign out_total_width   = res_rd.total_width;
  assign out_total_height  = res_rd.total_height;
  assign out_line_count    = res_rd.line_count;
  assign out_visible_index = res_rd.visible_index;
  assign out_wrapped       = res_rd.wrapped;
  assign out_string_done   = res_rd.string_done;

endmodule

// File: design/tllm_fifo.sv
// small register queue with count-based full and empty flags
module tllm_fifo import tllm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: design/tllm_front.sv
// input stage: takes code units, byte-swaps and classifies them into advance and newline
module tllm_front import tllm_pkg::*; #(
  parameter int NARROW_WIDTH = NARROW_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] code_unit,
  input  logic        first_of_string,
  input  logic        last_of_string,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  logic        valid_r, valid_nxt;
  item_t       item_r;
  item_t       item_cls;
  logic [15:0] code;
  logic        accept;

  assign code = {code_unit[7:0], code_unit[15:8]};

  always_comb begin
    item_cls.adv     = (code < 16'd128) ? ADV_W'(NARROW_WIDTH) : ADV_W'(WIDE_W);
    item_cls.newline = (code == NEWLINE_CODE);
    item_cls.first   = first_of_string;
    item_cls.last    = last_of_string;
  end

  assign q_push  = valid_r && !q_full;
  assign in_full = valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_cls;
    end
  end

endmodule

// File: design/tllm_back.sv
// layout stage: advances the pen, applies the wrap rules and keeps the running totals
module tllm_back import tllm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  lay_cfg_t cfg,
  input  logic     q_empty,
  input  item_t    q_item,
  output logic     q_pop,
  input  logic     res_full,
  output logic     res_push,
  output res_t     res
);

  logic [COORD_W-1:0] pen_x_r, pen_x_nxt;
  logic [COORD_W-1:0] pen_y_r, pen_y_nxt;
  logic [SUM_W-1:0]   width_r, width_nxt;
  logic [SUM_W-1:0]   height_r, height_nxt;
  logic [LINE_W-1:0]  lines_r, lines_nxt;
  logic [SUM_W-1:0]   vis_r, vis_nxt;

  logic [COORD_W-1:0]      base_x, base_y, px_adv, py_step;
  logic [SUM_W-1:0]        base_w, base_h, base_v;
  logic [LINE_W-1:0]       base_l;
  logic signed [EXT_W-1:0] px_ext, left_ext, py_ext, py_step_ext;
  logic [SUM_W:0]          w_sum, h_sum, v_sum;
  logic [LINE_W:0]         l_sum;
  logic                    over16, over8, brk, x_in, y_in;

  assign q_pop    = !q_empty && !res_full;
  assign res_push = q_pop;

  always_comb begin
    base_x = q_item.first ? cfg.start_x : pen_x_r;
    base_y = q_item.first ? cfg.start_y : pen_y_r;
    base_w = q_item.first ? '0 : width_r;
    base_h = q_item.first ? SUM_W'(FONT_H) : height_r;
    base_l = q_item.first ? LINE_W'(1) : lines_r;
    base_v = q_item.first ? cfg.start_offset : vis_r;

    px_adv      = base_x + COORD_W'(q_item.adv);
    py_step     = base_y + COORD_W'(LINE_STEP);
    px_ext      = EXT_W'($signed(px_adv));
    left_ext    = EXT_W'($signed(cfg.clip_left));
    py_ext      = EXT_W'($signed(base_y));
    py_step_ext = EXT_W'($signed(py_step));

    over16 = (px_ext + EXT_W'(WIDE_W)) > cfg.max_x;
    over8  = (px_ext + EXT_W'(HALF_W)) > cfg.max_x;
    brk    = (cfg.wrap_flags[WRAP_NEWLINE] && q_item.newline) ||
             (cfg.wrap_flags[WRAP_AUTO] && (over16 || q_item.newline)) ||
             (cfg.wrap_flags[WRAP_HALF] && (over8 || q_item.newline));

    w_sum = {1'b0, base_w} + (SUM_W + 1)'(q_item.adv);
    h_sum = {1'b0, base_h} + (SUM_W + 1)'(LINE_STEP);
    l_sum = {1'b0, base_l} + (LINE_W + 1)'(1);

    pen_x_nxt  = brk ? cfg.clip_left : px_adv;
    pen_y_nxt  = brk ? py_step : base_y;
    width_nxt  = w_sum[SUM_W] ? '1 : w_sum[SUM_W-1:0];
    height_nxt = base_h;
    lines_nxt  = base_l;
    if (brk) begin
      height_nxt = h_sum[SUM_W] ? '1 : h_sum[SUM_W-1:0];
      lines_nxt  = l_sum[LINE_W] ? '1 : l_sum[LINE_W-1:0];
    end

    x_in = brk ? (left_ext < cfg.max_x) : (px_ext < cfg.max_x);
    y_in = brk ? (py_step_ext < cfg.max_y) : (py_ext < cfg.max_y);

    v_sum   = {1'b0, base_v} + (SUM_W + 1)'(1);
    vis_nxt = base_v;
    if (x_in && y_in) begin
      vis_nxt = v_sum[SUM_W] ? '1 : v_sum[SUM_W-1:0];
    end

    res.pen_x         = pen_x_nxt;
    res.pen_y         = pen_y_nxt;
    res.total_width   = width_nxt;
    res.total_height  = height_nxt;
    res.line_count    = lines_nxt;
    res.visible_index = vis_nxt;
    res.wrapped       = brk;
    res.string_done   = q_item.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r  <= '0;
      pen_y_r  <= '0;
      width_r  <= '0;
      height_r <= SUM_W'(FONT_H);
      lines_r  <= LINE_W'(1);
      vis_r    <= '0;
    end else if (q_pop) begin
      pen_x_r  <= pen_x_nxt;
      pen_y_r  <= pen_y_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      lines_r  <= lines_nxt;
      vis_r    <= vis_nxt;
    end
  end

endmodule

// File: dv/layout_checker.sv
// layout checker: predicts each result beat of the layout measurer and compares it
module layout_checker import tllm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [15:0]        in_code_unit,
  input  logic               in_first_of_string,
  input  logic               in_last_of_string,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic signed [15:0] out_pen_x,
  input  logic signed [15:0] out_pen_y,
  input  logic [SUM_W-1:0]   out_total_width,
  input  logic [SUM_W-1:0]   out_total_height,
  input  logic [LINE_W-1:0]  out_line_count,
  input  logic [SUM_W-1:0]   out_visible_index,
  input  logic               out_wrapped,
  input  logic               out_string_done,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  output int                 mismatches,
  output int                 results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SUM_MAX  = (1 << SUM_W) - 1;
  localparam int LINE_MAX = (1 << LINE_W) - 1;

  logic signed [15:0] start_x_r, start_y_r, clip_left_r, clip_top_r;
  logic signed [15:0] clip_width_r, clip_height_r;
  logic [FLAG_W-1:0]  wrap_flags_r;
  logic [SUM_W-1:0]   start_offset_r;

  logic signed [15:0] pen_x_q, pen_y_q;
  logic [SUM_W-1:0]   width_acc, height_acc, visible_acc;
  logic [LINE_W-1:0]  lines_acc;

  res_t layout_due[$];

  function automatic int sat_add(int a, int b, int lim);
    return (a + b > lim) ? lim : a + b;
  endfunction

  function automatic res_t layout_char(logic [15:0] raw, logic first, logic last);
    logic [15:0] code;
    int          adv;
    int          max_x;
    int          max_y;
    int          px;
    logic        nl;
    logic        brk;
    res_t        r;
    code  = {raw[7:0], raw[15:8]};
    adv   = (code < 128) ? NARROW_WIDTH_DEF : WIDE_W;
    max_x = int'(clip_left_r) + int'(clip_width_r);
    max_y = int'(clip_top_r) + int'(clip_height_r);
    if (max_x > SCREEN_W_DEF) max_x = SCREEN_W_DEF;
    if (max_y > SCREEN_H_DEF) max_y = SCREEN_H_DEF;
    if (first) begin
      pen_x_q     = start_x_r;
      pen_y_q     = start_y_r;
      width_acc   = '0;
      height_acc  = SUM_W'(FONT_H);
      lines_acc   = LINE_W'(1);
      visible_acc = start_offset_r;
    end
    pen_x_q   = pen_x_q + 16'(adv);
    width_acc = SUM_W'(sat_add(int'(width_acc), adv, SUM_MAX));
    px        = int'(pen_x_q);
    nl        = (code == NEWLINE_CODE);
    brk = (wrap_flags_r[WRAP_NEWLINE] && nl) ||
          (wrap_flags_r[WRAP_AUTO] && (px + WIDE_W > max_x || nl)) ||
          (wrap_flags_r[WRAP_HALF] && (px + HALF_W > max_x || nl));
    if (brk) begin
      pen_x_q    = clip_left_r;
      pen_y_q    = pen_y_q + 16'(LINE_STEP);
      height_acc = SUM_W'(sat_add(int'(height_acc), LINE_STEP, SUM_MAX));
      lines_acc  = LINE_W'(sat_add(int'(lines_acc), 1, LINE_MAX));
    end
    if (int'(pen_x_q) < max_x && int'(pen_y_q) < max_y)
      visible_acc = SUM_W'(sat_add(int'(visible_acc), 1, SUM_MAX));
    r.pen_x         = pen_x_q;
    r.pen_y         = pen_y_q;
    r.total_width   = width_acc;
    r.total_height  = height_acc;
    r.line_count    = lines_acc;
    r.visible_index = visible_acc;
    r.wrapped       = brk;
    r.string_done   = last;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      start_x_r      = '0;
      start_y_r      = '0;
      clip_left_r    = '0;
      clip_top_r     = '0;
      clip_width_r   = 16'(RESET_CLIP_W);
      clip_height_r  = 16'(RESET_CLIP_H);
      wrap_flags_r   = '0;
      start_offset_r = '0;
      pen_x_q        = '0;
      pen_y_q        = '0;
      width_acc      = '0;
      height_acc     = SUM_W'(FONT_H);
      lines_acc      = LINE_W'(1);
      visible_acc    = '0;
      mismatches     = 0;
      layout_due.delete();
      results_due   <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_START_X:      start_x_r      = cfg_data[15:0];
          CFG_START_Y:      start_y_r      = cfg_data[15:0];
          CFG_CLIP_LEFT:    clip_left_r    = cfg_data[15:0];
          CFG_CLIP_TOP:     clip_top_r     = cfg_data[15:0];
          CFG_CLIP_WIDTH:   clip_width_r   = cfg_data[15:0];
          CFG_CLIP_HEIGHT:  clip_height_r  = cfg_data[15:0];
          CFG_WRAP_FLAGS:   wrap_flags_r   = cfg_data[FLAG_W-1:0];
          CFG_START_OFFSET: start_offset_r = cfg_data[SUM_W-1:0];
          default: ;
        endcase
      end
      // result beat is checked before the new input beat is predicted
      if (out_pop && !out_empty) begin
        if (layout_due.size() == 0) begin
          report_mismatch("result beat with nothing expected",
                          32'($unsigned(out_pen_x)), '0);
        end else begin
          want = layout_due.pop_front();
          if (out_pen_x !== want.pen_x)
            report_mismatch("pen_x", 32'($unsigned(out_pen_x)), 32'(want.pen_x));
          if (out_pen_y !== want.pen_y)
            report_mismatch("pen_y", 32'($unsigned(out_pen_y)), 32'(want.pen_y));
          if (out_total_width !== want.total_width)
            report_mismatch("total_width", 32'(out_total_width), 32'(want.total_width));
          if (out_total_height !== want.total_height)
            report_mismatch("total_height", 32'(out_total_height),
                            32'(want.total_height));
          if (out_line_count !== want.line_count)
            report_mismatch("line_count", 32'(out_line_count), 32'(want.line_count));
          if (out_visible_index !== want.visible_index)
            report_mismatch("visible_index", 32'(out_visible_index),
                            32'(want.visible_index));
          if (out_wrapped !== want.wrapped)
            report_mismatch("wrapped", 32'(out_wrapped), 32'(want.wrapped));
          if (out_string_done !== want.string_done)
            report_mismatch("string_done", 32'(out_string_done), 32'(want.string_done));
        end
      end
      if (in_push && !in_full)
        layout_due.push_back(layout_char(in_code_unit, in_first_of_string,
                                         in_last_of_string));
      results_due <= layout_due.size();
    end
  end

endmodule

// File: dv/testbench.sv
// testbench top: clock, reset, character stimulus, config phases and verdict
module testbench import tllm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STALL_LIMIT = 1000;
  localparam int          DRAIN_WAIT  = 4;
  localparam int          PHASE_ITEMS = 78;
  localparam logic [15:0] NEWLINE_RAW = {NEWLINE_CODE[7:0], NEWLINE_CODE[15:8]};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [15:0]        in_code_unit = '0;
  logic               in_first_of_string = 1'b0;
  logic               in_last_of_string = 1'b0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [15:0] out_pen_x;
  logic signed [15:0] out_pen_y;
  logic [SUM_W-1:0]   out_total_width;
  logic [SUM_W-1:0]   out_total_height;
  logic [LINE_W-1:0]  out_line_count;
  logic [SUM_W-1:0]   out_visible_index;
  logic               out_wrapped;
  logic               out_string_done;
  logic               cfg_we = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  int mismatches;
  int results_due;
  int send_idle = 0;
  int recv_idle = 0;
  int idle_cycles = 0;

  logic [CFG_W-1:0] cfg_vals [8];

  text_line_layout_measure i_dut (.*);

  layout_checker i_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) out_pop <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_char(logic [15:0] code, logic first, logic last);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push            <= 1'b1;
    in_code_unit       <= code;
    in_first_of_string <= first;
    in_last_of_string  <= last;
    do @(posedge clk); while (in_full);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_config();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data  <= cfg_vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic void default_config();
    cfg_vals[CFG_START_X]      = '0;
    cfg_vals[CFG_START_Y]      = '0;
    cfg_vals[CFG_CLIP_LEFT]    = '0;
    cfg_vals[CFG_CLIP_TOP]     = '0;
    cfg_vals[CFG_CLIP_WIDTH]   = CFG_W'(RESET_CLIP_W);
    cfg_vals[CFG_CLIP_HEIGHT]  = CFG_W'(RESET_CLIP_H);
    cfg_vals[CFG_WRAP_FLAGS]   = '0;
    cfg_vals[CFG_START_OFFSET] = '0;
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'($urandom_range(200));
      4:       return -16'($urandom_range(200));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void random_config();
    cfg_vals[CFG_START_X]     = CFG_W'(($urandom_range(3) == 0) ? pick_coord()
                                       : 16'($urandom_range(120)));
    cfg_vals[CFG_START_Y]     = CFG_W'(($urandom_range(3) == 0) ? pick_coord()
                                       : 16'($urandom_range(200)));
    cfg_vals[CFG_CLIP_LEFT]   = CFG_W'(($urandom_range(3) == 0) ? pick_coord()
                                       : 16'($urandom_range(100)));
    cfg_vals[CFG_CLIP_TOP]    = CFG_W'(($urandom_range(3) == 0) ? pick_coord()
                                       : 16'($urandom_range(100)));
    cfg_vals[CFG_CLIP_WIDTH]  = CFG_W'(($urandom_range(3) == 0) ? pick_coord()
                                       : 16'($urandom_range(8, 160)));
    cfg_vals[CFG_CLIP_HEIGHT] = CFG_W'(($urandom_range(3) == 0) ? pick_coord()
                                       : 16'($urandom_range(20, 400)));
    cfg_vals[CFG_WRAP_FLAGS]  = CFG_W'($urandom_range(7));
    cfg_vals[CFG_START_OFFSET] = ($urandom_range(3) == 0) ? CFG_W'(20'hFFFFF)
                                                           : CFG_W'($urandom);
  endfunction

  function automatic logic [15:0] rand_code();
    case ($urandom_range(9))
      0, 1, 2, 3: return {1'b0, 7'($urandom), 8'h00};
      4, 5:       return NEWLINE_RAW;
      9:          return {1'b1, 7'($urandom), 8'h00};
      default:    return 16'($urandom);
    endcase
  endfunction

  // mostly well-formed strings, some with scrambled first and last beats
  task automatic send_string(inout int sent);
    int   len;
    logic noise;
    logic first;
    logic last;
    len   = $urandom_range(1, 16);
    noise = ($urandom_range(9) == 0);
    for (int k = 0; k < len; k++) begin
      first = noise ? 1'($urandom) : (k == 0);
      last  = noise ? 1'($urandom) : (k == len - 1);
      push_char(rand_code(), first, last);
      sent++;
    end
  endtask

  initial begin
    int sent;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state, no string start
    push_char(16'h4100, 1'b0, 1'b0);
    push_char(16'h0041, 1'b0, 1'b0);
    push_char(16'hFFFF, 1'b0, 1'b0);
    push_char(16'h0000, 1'b0, 1'b1);

    drain();
    default_config();
    cfg_vals[CFG_WRAP_FLAGS] = CFG_W'(1 << WRAP_NEWLINE);
    write_config();
    push_char(16'h4800, 1'b1, 1'b0);
    push_char(NEWLINE_RAW, 1'b0, 1'b0);
    push_char(16'h7F00, 1'b0, 1'b0);
    push_char(16'h8000, 1'b0, 1'b0);
    push_char(16'h00FF, 1'b0, 1'b1);

    foreach (cfg_vals[j]) begin
      if (j == WRAP_AUTO || j == WRAP_HALF) begin
        drain();
        default_config();
        cfg_vals[CFG_CLIP_WIDTH] = CFG_W'(40);
        cfg_vals[CFG_WRAP_FLAGS] = CFG_W'(1 << j);
        write_config();
        push_char(16'h0041, 1'b1, 1'b0);
        push_char(16'h0041, 1'b0, 1'b0);
        push_char(16'h4100, 1'b0, 1'b0);
        push_char(NEWLINE_RAW, 1'b0, 1'b0);
        push_char(16'h0041, 1'b0, 1'b1);
      end
    end

    // most negative rectangle, all wrap rules
    drain();
    cfg_vals[CFG_START_X]      = CFG_W'(16'h7FF8);
    cfg_vals[CFG_START_Y]      = CFG_W'(16'h7FFF);
    cfg_vals[CFG_CLIP_LEFT]    = CFG_W'(16'h8000);
    cfg_vals[CFG_CLIP_TOP]     = CFG_W'(16'h7FFF);
    cfg_vals[CFG_CLIP_WIDTH]   = CFG_W'(16'h8000);
    cfg_vals[CFG_CLIP_HEIGHT]  = CFG_W'(16'h7FFF);
    cfg_vals[CFG_WRAP_FLAGS]   = CFG_W'(3'b111);
    cfg_vals[CFG_START_OFFSET] = CFG_W'(20'hFFFFF);
    write_config();
    push_char(16'h0041, 1'b1, 1'b0);
    push_char(16'h4100, 1'b0, 1'b0);
    push_char(NEWLINE_RAW, 1'b0, 1'b0);
    push_char(16'hFFFF, 1'b0, 1'b1);

    // pen x wraps past the top of the coordinate range
    drain();
    cfg_vals[CFG_START_Y]     = CFG_W'(16'h8000);
    cfg_vals[CFG_CLIP_LEFT]   = CFG_W'(16'h7FFF);
    cfg_vals[CFG_CLIP_WIDTH]  = CFG_W'(16'h7FFF);
    cfg_vals[CFG_CLIP_TOP]    = CFG_W'(16'h8000);
    cfg_vals[CFG_WRAP_FLAGS]  = '0;
    write_config();
    push_char(16'h0041, 1'b1, 1'b0);
    push_char(16'h0041, 1'b0, 1'b0);
    push_char(16'h4100, 1'b0, 1'b1);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 7 : (mode == 1) ? 77 : 0;
      recv_idle = (mode == 0) ? 77 : (mode == 1) ? 7 : 0;
      repeat (4) begin
        drain();
        random_config();
        write_config();
        sent = 0;
        while (sent < PHASE_ITEMS) send_string(sent);
      end
    end

    drain();
    if (mismatches == 0 && results_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/tllm_pkg.sv
design/tllm_fifo.sv
design/tllm_front.sv
design/tllm_back.sv
design/text_line_layout_measure.sv
dv/layout_checker.sv
dv/testbench.sv
